@@ sv/spat_pkg.sv @@
// Package with the shared types, codes and defaults of the segmented paged address translator.
`timescale 1ns / 1ps
package spat_pkg;

    localparam int NUM_PROCS_DEF   = 16;
    localparam int NUM_SEGS_DEF    = 8;
    localparam int MAX_PAGES_DEF   = 16;
    localparam int FRAME_SLOTS_DEF = 256;
    localparam int PAGE_BYTES_DEF  = 4096;

    localparam int PROC_W   = 4;
    localparam int SEG_W    = 3;
    localparam int PAGE_W   = 4;
    localparam int OFF_W    = 16;
    localparam int BYTES_W  = 17;
    localparam int STATUS_W = 4;
    localparam int PHYS_W   = 20;
    localparam int FRAME_W  = 8;
    localparam int PAGES_W  = 9;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;
    localparam int QDEPTH   = 2;

    typedef enum logic [1:0] {
        MODE_CREATE    = 2'd0,
        MODE_ADD_SEG   = 2'd1,
        MODE_LOAD      = 2'd2,
        MODE_TRANSLATE = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_OFFSET    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PROC   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_SEG_FAULT = 4'd3;
    localparam logic [STATUS_W-1:0] ST_PAGE_OOB  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_LOAD  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OOM       = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_OVERWR    = 4'd8;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } bk_state_t;

    typedef struct packed {
        mode_t              mode;
        logic               pid_ok;
        logic               seg_ok;
        logic               off_ok;
        logic               page_ok;
        logic [PROC_W-1:0]  proc_id;
        logic [SEG_W-1:0]   seg_num;
        logic [PAGE_W-1:0]  page_num;
        logic [OFF_W-1:0]   byte_offset;
        logic [PAGES_W-1:0] pages;
    } req_t;

endpackage

@@ sv/spat_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module spat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/spat_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module spat_front
    import spat_pkg::*;
#(
    parameter int NUM_PROCS  = NUM_PROCS_DEF,
    parameter int NUM_SEGS   = NUM_SEGS_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                head_valid,
    output req_t                head,
    input  logic                pop
);

    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    req_t              q_reg [QDEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    req_t              req;
    logic              push;
    logic [PROC_W-1:0] f_proc;
    logic [SEG_W-1:0]  f_seg;
    logic [PAGE_W-1:0] f_page;
    logic [OFF_W-1:0]  f_off;
    logic [BYTES_W-1:0] f_bytes;
    logic [31:0]       pages_raw;

    assign f_proc  = s_tdata[3:0];
    assign f_seg   = s_tdata[6:4];
    assign f_page  = s_tdata[10:7];
    assign f_off   = s_tdata[26:11];
    assign f_bytes = s_tdata[43:27];

    always_comb
    begin
        pages_raw        = (32'(f_bytes) + 32'(PAGE_BYTES - 1)) / PAGE_BYTES;
        req.mode         = mode_t'(s_tuser);
        req.pid_ok       = (32'(f_proc) < 32'(NUM_PROCS));
        req.seg_ok       = (32'(f_seg) < 32'(NUM_SEGS));
        req.off_ok       = (32'(f_off) < 32'(PAGE_BYTES));
        req.page_ok      = (32'(f_page) < 32'(MAX_PAGES));
        req.proc_id      = f_proc;
        req.seg_num      = f_seg;
        req.page_num     = f_page;
        req.byte_offset  = f_off;
        req.pages        = (pages_raw > 32'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES)
                                                        : PAGES_W'(pages_raw);
    end

    assign s_tready   = (cnt_reg != CNT_W'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= req;
        end
    end

endmodule

@@ sv/spat_back.sv @@
// Back end: reads the page tables, applies the request and registers the result.
`timescale 1ns / 1ps
module spat_back
    import spat_pkg::*;
#(
    parameter int NUM_PROCS   = NUM_PROCS_DEF,
    parameter int NUM_SEGS    = NUM_SEGS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF,
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  req_t                head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SLOTS  = NUM_PROCS * NUM_SEGS;
    localparam int FSLOTS = SLOTS * MAX_PAGES;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FAW    = (FSLOTS > 1) ? $clog2(FSLOTS) : 1;
    localparam int PPW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PIW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW     = $clog2(MAX_PAGES + 1);
    localparam int FW     = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int FCW    = $clog2(FRAME_SLOTS + 1);

    bk_state_t           state_reg, state_next;
    logic [NUM_PROCS-1:0] proc_valid_reg, proc_valid_next;
    logic [SLOTS-1:0]    seg_valid_reg, seg_valid_next;
    logic [FCW-1:0]      fcount_reg, fcount_next;
    req_t                cur_reg;
    logic [SW-1:0]       slot_reg;
    logic [PIW-1:0]      pidx_reg;
    logic [FAW-1:0]      faddr_reg;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [SW-1:0]       h_slot;
    logic [PIW-1:0]      h_pidx;
    logic [FAW-1:0]      h_faddr;
    logic                rd_en;
    logic [CW-1:0]       cnt_rdata;
    logic [MAX_PAGES-1:0] pres_rdata;
    logic [FW-1:0]       fr_rdata;
    logic                cnt_we, pres_we, fr_we;
    logic [CW-1:0]       cnt_wdata;
    logic [MAX_PAGES-1:0] pres_wdata;
    logic [FW-1:0]       fr_wdata;
    logic [STATUS_W-1:0] status, find_st;
    logic [PHYS_W-1:0]   phys;
    logic [FRAME_W-1:0]  frame;
    logic                pv;
    logic                page_lt_cnt;
    logic [31:0]         pa;

    assign h_slot  = SW'(32'(head.proc_id) * NUM_SEGS + 32'(head.seg_num));
    assign h_pidx  = PIW'(head.page_num);
    assign h_faddr = FAW'(32'(h_slot) * MAX_PAGES + 32'(h_pidx));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && (!out_valid_reg || m_tready))
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop   = 1'b0;
        rd_en = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop   = head_valid && (!out_valid_reg || m_tready);
                rd_en = pop;
            end
            default:
            begin
                pop   = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pv          = cur_reg.pid_ok && proc_valid_reg[PPW'(cur_reg.proc_id)];
        page_lt_cnt = (32'(cur_reg.page_num) < 32'(cnt_rdata));
        if (!pv)
        begin
            find_st = ST_NO_PROC;
        end
        else if (!cur_reg.seg_ok || !seg_valid_reg[slot_reg])
        begin
            find_st = ST_SEG_FAULT;
        end
        else
        begin
            find_st = ST_OK;
        end

        status          = ST_OK;
        phys            = '0;
        frame           = '0;
        pa              = '0;
        proc_valid_next = proc_valid_reg;
        seg_valid_next  = seg_valid_reg;
        fcount_next     = fcount_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = CW'(cur_reg.pages);
        pres_we         = 1'b0;
        pres_wdata      = '0;
        fr_we           = 1'b0;
        fr_wdata        = FW'(fcount_reg);

        if (state_reg == BK_EXEC)
        begin
            case (cur_reg.mode)
                MODE_CREATE:
                begin
                    if (!cur_reg.pid_ok)
                    begin
                        status = ST_NO_PROC;
                    end
                    else if (pv)
                    begin
                        status = ST_EXISTS;
                    end
                    else
                    begin
                        proc_valid_next[PPW'(cur_reg.proc_id)] = 1'b1;
                    end
                end
                MODE_ADD_SEG:
                begin
                    if (!pv)
                    begin
                        status = ST_NO_PROC;
                    end
                    else if (!cur_reg.seg_ok)
                    begin
                        status = ST_SEG_FAULT;
                    end
                    else
                    begin
                        status = seg_valid_reg[slot_reg] ? ST_OVERWR : ST_OK;
                        seg_valid_next[slot_reg] = 1'b1;
                        cnt_we  = 1'b1;
                        pres_we = 1'b1;
                    end
                end
                MODE_LOAD:
                begin
                    if (fcount_reg == FCW'(FRAME_SLOTS))
                    begin
                        status = ST_OOM;
                    end
                    else
                    begin
                        fcount_next = fcount_reg + 1'b1;
                        status      = find_st;
                        if (status == ST_OK && !page_lt_cnt)
                        begin
                            status = ST_PAGE_OOB;
                        end
                        if (status == ST_OK)
                        begin
                            pres_we               = 1'b1;
                            pres_wdata            = pres_rdata;
                            pres_wdata[pidx_reg]  = 1'b1;
                            fr_we                 = 1'b1;
                            frame                 = FRAME_W'(fcount_reg);
                        end
                    end
                end
                MODE_TRANSLATE:
                begin
                    if (!cur_reg.off_ok)
                    begin
                        status = ST_OFFSET;
                    end
                    else
                    begin
                        status = find_st;
                        if (status == ST_OK && (!page_lt_cnt || !cur_reg.page_ok))
                        begin
                            status = ST_PAGE_OOB;
                        end
                        if (status == ST_OK && !pres_rdata[pidx_reg])
                        begin
                            status = ST_NOT_LOAD;
                        end
                        if (status == ST_OK)
                        begin
                            pa   = 32'(fr_rdata) * PAGE_BYTES + 32'(cur_reg.byte_offset);
                            phys = pa[PHYS_W-1:0];
                        end
                    end
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (state_reg == BK_EXEC)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {frame, phys, status};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            proc_valid_reg <= '0;
            seg_valid_reg  <= '0;
            fcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_valid_reg <= proc_valid_next;
            seg_valid_reg  <= seg_valid_next;
            fcount_reg     <= fcount_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop)
        begin
            cur_reg   <= head;
            slot_reg  <= h_slot;
            pidx_reg  <= h_pidx;
            faddr_reg <= h_faddr;
        end
    end

    spat_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (slot_reg),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (h_slot),
        .rdata (cnt_rdata)
    );

    spat_ram #(.WIDTH(MAX_PAGES), .DEPTH(SLOTS)) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (slot_reg),
        .wdata (pres_wdata),
        .re    (rd_en),
        .raddr (h_slot),
        .rdata (pres_rdata)
    );

    spat_ram #(.WIDTH(FW), .DEPTH(FSLOTS)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (faddr_reg),
        .wdata (fr_wdata),
        .re    (rd_en),
        .raddr (h_faddr),
        .rdata (fr_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ sv/segmented_paged_address_translator.sv @@
// Top level of the segmented paged address translator.
//
// Channel  Direction  Carries
// s_*      in         one request: mode in tuser, ids, page, offset and size in tdata
// m_*      out        one result per request: status, physical address, frame
//
// In the back end a request is popped and its segment and page tables are read from
// their RAMs in state BK_IDLE; in BK_EXEC they are checked and updated and the
// result is registered.
// Frames are handed out in ascending order, so a fill count stands for the
// used-frame map and reset needs no clearing pass.
// A two-entry queue between front and back accepts input while a result waits, until full.
`timescale 1ns / 1ps
module segmented_paged_address_translator
    import spat_pkg::*;
#(
    parameter int NUM_PROCS   = NUM_PROCS_DEF,
    parameter int NUM_SEGS    = NUM_SEGS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF,
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // Fields from bit 0: proc_id[4], seg_num[3], page_num[4], byte_offset[16], seg_bytes[17].
    input  logic [S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: mode[2].
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0: status[4], phys_addr[20], frame_num[8].
    output logic [M_DATA_W-1:0] m_tdata
);

    req_t head;
    logic head_valid;
    logic pop;

    spat_front #(
        .NUM_PROCS  (NUM_PROCS),
        .NUM_SEGS   (NUM_SEGS),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    spat_back #(
        .NUM_PROCS   (NUM_PROCS),
        .NUM_SEGS    (NUM_SEGS),
        .MAX_PAGES   (MAX_PAGES),
        .FRAME_SLOTS (FRAME_SLOTS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ sv/spat_checker.sv @@
// Port-level checker for the segmented paged address translator, with its bind.
`timescale 1ns / 1ps
module spat_checker
    import spat_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= ST_OVERWR)
        else $error("Status code out of range.");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] != ST_OK |-> m_tdata[31:4] == '0)
        else $error("Faulted result carries an address or frame.");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:4] == '0 || m_tdata[31:24] == '0)
        else $error("Result carries both an address and a frame.");

endmodule

bind segmented_paged_address_translator spat_checker u_spat_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb_segmented_paged_address_translator.sv @@
// Self-checking testbench for the segmented paged address translator.
`timescale 1ns / 1ps
module tb_segmented_paged_address_translator;
    import spat_pkg::*;

    localparam int N_PROCS   = 16;
    localparam int N_SEGS    = 8;
    localparam int N_PAGES   = 16;
    localparam int N_FRAMES  = 256;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1130;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PHYS_W-1:0]   phys_addr;
        logic [FRAME_W-1:0]  frame_num;
    } mmu_result_t;

    class mmu_scoreboard;
        bit                 proc_live [N_PROCS];
        bit                 seg_live  [N_PROCS*N_SEGS];
        int                 seg_pages [N_PROCS*N_SEGS];
        bit [N_PAGES-1:0]   mapped    [N_PROCS*N_SEGS];
        bit [FRAME_W-1:0]   frame_of  [N_PROCS*N_SEGS*N_PAGES];
        int                 frames_taken;
        mmu_result_t        pending_results[$];
        int                 errors;

        function int lookup_seg(logic [PROC_W-1:0] pid, logic [SEG_W-1:0] seg, output int slot);
            slot = pid * N_SEGS + seg;
            if (!proc_live[pid])
                return ST_NO_PROC;
            if (!seg_live[slot])
                return ST_SEG_FAULT;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] mode_bits, logic [S_DATA_W-1:0] data);
            mode_t              mode;
            logic [PROC_W-1:0]  pid;
            logic [SEG_W-1:0]   seg;
            logic [PAGE_W-1:0]  page;
            logic [OFF_W-1:0]   off;
            logic [BYTES_W-1:0] nbytes;
            mmu_result_t        res;
            int                 slot;
            int                 pages;
            int                 got;
            mode   = mode_t'(mode_bits);
            pid    = data[3:0];
            seg    = data[6:4];
            page   = data[10:7];
            off    = data[26:11];
            nbytes = data[43:27];
            res    = '0;
            case (mode)
                MODE_CREATE: begin
                    if (proc_live[pid])
                        res.status = ST_EXISTS;
                    else
                        proc_live[pid] = 1'b1;
                end
                MODE_ADD_SEG: begin
                    if (!proc_live[pid])
                        res.status = ST_NO_PROC;
                    else
                    begin
                        slot  = pid * N_SEGS + seg;
                        pages = (int'(nbytes) + 4095) / 4096;
                        if (pages > N_PAGES)
                            pages = N_PAGES;
                        if (seg_live[slot])
                            res.status = ST_OVERWR;
                        seg_live[slot]  = 1'b1;
                        seg_pages[slot] = pages;
                        mapped[slot]    = '0;
                    end
                end
                MODE_LOAD: begin
                    if (frames_taken >= N_FRAMES)
                        res.status = ST_OOM;
                    else
                    begin
                        got = frames_taken;
                        frames_taken++;
                        res.status = STATUS_W'(lookup_seg(pid, seg, slot));
                        if (res.status == ST_OK && page >= seg_pages[slot])
                            res.status = ST_PAGE_OOB;
                        if (res.status == ST_OK)
                        begin
                            mapped[slot][page]             = 1'b1;
                            frame_of[slot*N_PAGES + page]  = got[FRAME_W-1:0];
                            res.frame_num                  = got[FRAME_W-1:0];
                        end
                    end
                end
                default: begin
                    if (off >= 4096)
                        res.status = ST_OFFSET;
                    else
                    begin
                        res.status = STATUS_W'(lookup_seg(pid, seg, slot));
                        if (res.status == ST_OK && page >= seg_pages[slot])
                            res.status = ST_PAGE_OOB;
                        if (res.status == ST_OK && !mapped[slot][page])
                            res.status = ST_NOT_LOAD;
                        if (res.status == ST_OK)
                            res.phys_addr = {frame_of[slot*N_PAGES + page], off[11:0]};
                    end
                end
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            mmu_result_t want;
            logic [STATUS_W-1:0] got_status;
            logic [PHYS_W-1:0]   got_phys;
            logic [FRAME_W-1:0]  got_frame;
            got_status = data[3:0];
            got_phys   = data[23:4];
            got_frame  = data[31:24];
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result transaction: %h", data);
                return;
            end
            want = pending_results.pop_front();
            if (got_status != want.status || got_phys != want.phys_addr
                || got_frame != want.frame_num)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected status %0d phys %h frame %0d,",
                              " got status %0d phys %h frame %0d"},
                             want.status, want.phys_addr, want.frame_num,
                             got_status, got_phys, got_frame);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    mmu_scoreboard sb;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    segmented_paged_address_translator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_request(mode_t mode, int pid, int seg, int page, int off, int nbytes);
        int gap;
        @(negedge clk);
        s_tuser  = mode;
        s_tdata  = '0;
        s_tdata[3:0]   = pid[3:0];
        s_tdata[6:4]   = seg[2:0];
        s_tdata[10:7]  = page[3:0];
        s_tdata[26:11] = off[15:0];
        s_tdata[43:27] = nbytes[16:0];
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_random();
        int    pick;
        mode_t mode;
        int    pid;
        int    seg;
        int    page;
        int    off;
        int    nbytes;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            mode = MODE_CREATE;
        else if (pick < 20)
            mode = MODE_ADD_SEG;
        else if (pick < 50)
            mode = MODE_LOAD;
        else
            mode = MODE_TRANSLATE;
        pid  = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        seg  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 7);
        page = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 15);
        off  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4095) : $urandom_range(0, 65535);
        nbytes = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 131071)
                                              : $urandom_range(1, 40000);
        send_request(mode, pid, seg, page, off, nbytes);
    endtask

    initial
    begin
        sb           = new();
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b1;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(MODE_ADD_SEG,   0, 0, 0, 0, 4096);
        send_request(MODE_LOAD,      0, 0, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 0, 0, 0, 0);
        send_request(MODE_CREATE,    0, 0, 0, 0, 0);
        send_request(MODE_CREATE,    0, 0, 0, 0, 0);
        send_request(MODE_CREATE,   15, 0, 0, 0, 0);
        send_request(MODE_LOAD,      0, 7, 0, 0, 0);
        send_request(MODE_ADD_SEG,   0, 0, 0, 0, 0);
        send_request(MODE_LOAD,      0, 0, 0, 0, 0);
        send_request(MODE_ADD_SEG,   0, 0, 0, 0, 4097);
        send_request(MODE_ADD_SEG,  15, 7, 0, 0, 131071);
        send_request(MODE_ADD_SEG,   0, 1, 0, 0, 65536);
        send_request(MODE_LOAD,      0, 0, 1, 0, 0);
        send_request(MODE_LOAD,      0, 0, 2, 0, 0);
        send_request(MODE_LOAD,     15, 7, 15, 0, 0);
        send_request(MODE_TRANSLATE, 15, 7, 15, 4095, 0);
        send_request(MODE_TRANSLATE, 0, 0, 1, 4096, 0);
        send_request(MODE_TRANSLATE, 0, 0, 1, 65535, 0);
        send_request(MODE_TRANSLATE, 3, 0, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 5, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 0, 2, 0, 0);
        send_request(MODE_TRANSLATE, 0, 1, 0, 10, 0);
        send_request(MODE_LOAD,      0, 1, 0, 0, 0);
        send_request(MODE_TRANSLATE, 0, 1, 0, 10, 0);
        drain_results();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 283 == 0)
            begin
                drain_results();
                case (i / 283)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 56; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 56; end
                    default: begin idle_pct = 33; stall_pct = 33; end
                endcase
            end
            send_random();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
